// File: design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pht_pkg.sv
// Package: constants, register codes, sine ROM builder and helpers for the thermostat.
package pht_pkg;

    localparam int SINE_AW = 10;
    localparam int SINE_DEPTH = 1 << SINE_AW;
    localparam int QW = 16;
    localparam int PHASE_BITS_DEF = 10;
    localparam logic [31:0] MIN_SWITCH_INTERVAL_MS = 32'd30000;

    localparam logic [2:0] REG_IS_HEATER = 3'd0;
    localparam logic [2:0] REG_PROFILE_MODE = 3'd1;
    localparam logic [2:0] REG_BASE_TARGET = 3'd2;
    localparam logic [2:0] REG_HYST_DELTA = 3'd3;
    localparam logic [2:0] REG_START_TIME = 3'd4;
    localparam logic [2:0] REG_LENGTH = 3'd5;
    localparam logic [2:0] REG_RAMP_START = 3'd6;
    localparam logic [2:0] REG_SINE_AMP = 3'd7;

    localparam logic [1:0] MODE_FLAT = 2'd0;
    localparam logic [1:0] MODE_RAMP = 2'd1;
    localparam logic [1:0] MODE_SINE = 2'd2;

    typedef logic signed [15:0] sine_rom_t [SINE_DEPTH];

    // Q30 polynomial for sin(pi/2*u), u = x/256, rounded to Q15
    function automatic logic [15:0] quarter_sine(input logic [8:0] x);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] q;
        u = 64'(x) << 22;
        u2 = (u * u) >> 30;
        p = 64'd172272;
        p = 64'd5026995 - ((p * u2) >> 30);
        p = 64'd85569306 - ((p * u2) >> 30);
        p = 64'd693598669 - ((p * u2) >> 30);
        p = 64'd1686629713 - ((p * u2) >> 30);
        s = (p * u) >> 30;
        q = (s + 64'd16384) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return q[15:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        logic [15:0] v;
        logic [1:0] quad;
        logic [8:0] r;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            quad = 2'(i >> 8);
            r = 9'(i & 255);
            v = quad[0] ? quarter_sine(9'd256 - r) : quarter_sine(r);
            rom[i] = quad[1] ? -$signed(v) : $signed(v);
        end
        return rom;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -18'sd32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

// File: design/profiled_hysteresis_thermostat_unit.sv
// Top level: profiled setpoint generator with hysteresis drive control.
//
//  channel | direction | handshake            | beat contents
//  in      | input     | in_valid / in_stall  | now_seconds, now_ms, temperature, calibrating
//  out     | output    | out_valid / out_stall| drive_on, target_temperature, drive_changed
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// Per beat: IDLE, PREP, then DIV, FIN (ramp) or DIV, ROM, MUL, FIN (sine), then DECIDE; flat goes PREP to DECIDE.
// The result register loads as DECIDE hands back to IDLE, ahead of the next accept. A ramp outside its
// span is flat. The serial restoring divider on the ramp and sine paths makes one quotient bit per cycle.
// Reset loads the register defaults; the sine ROM is constant logic, no fill pass.
// The core takes a new beat once its result sits in the output register, so a stalled
// output holds at most one finished beat while the next one is worked on.
module profiled_hysteresis_thermostat_unit #(
    parameter int PHASE_BITS = pht_pkg::PHASE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        now_seconds,
    input  logic [31:0]        now_ms,
    input  logic signed [15:0] temperature,
    input  logic               calibrating,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               drive_on,
    output logic signed [15:0] target_temperature,
    output logic               drive_changed,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_DIV = 3'd2;
    localparam logic [2:0] ST_ROM = 3'd3;
    localparam logic [2:0] ST_MUL = 3'd4;
    localparam logic [2:0] ST_FIN = 3'd5;
    localparam logic [2:0] ST_DECIDE = 3'd6;

    localparam int SH_R = (PHASE_BITS >= pht_pkg::SINE_AW) ? PHASE_BITS - pht_pkg::SINE_AW : 0;
    localparam int SH_L = (PHASE_BITS >= pht_pkg::SINE_AW) ? 0 : pht_pkg::SINE_AW - PHASE_BITS;
    localparam pht_pkg::sine_rom_t SINE_ROM = pht_pkg::build_sine_rom();

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic               is_heater_reg;
    logic [1:0]         mode_reg;
    logic signed [15:0] base_reg;
    logic [12:0]        delta_reg;
    logic [31:0]        start_reg;
    logic [31:0]        len_reg;
    logic signed [15:0] rs_reg;
    logic signed [15:0] amp_reg;

    logic        drive_reg;
    logic [31:0] last_ms_reg;
    logic [31:0] scs_reg;

    logic [31:0]        now_s_reg;
    logic [31:0]        now_ms_reg;
    logic signed [15:0] temp_reg;
    logic               cal_reg;

    logic [31:0]               rem_reg;
    logic [pht_pkg::QW-1:0]    quo_reg;
    logic [4:0]                cnt_reg;
    logic                      neg_reg;
    logic signed [15:0]        rom_reg;
    logic signed [31:0]        prod_reg;
    logic signed [15:0]        tgt_reg;

    logic               out_valid_reg;
    logic               out_drive_reg;
    logic signed [15:0] out_tgt_reg;
    logic               out_chg_reg;

    // prep datapath
    logic [31:0]        off;
    logic [31:0]        el;
    logic               el_wrap;
    logic signed [16:0] diff;
    logic [15:0]        mag;
    logic [47:0]        mul;
    logic               ramp_go;
    logic               sine_go;

    // divider step
    logic [32:0] dext;
    logic        dge;
    logic [32:0] dsub;

    logic [PHASE_BITS-1:0]       phase;
    logic [pht_pkg::SINE_AW-1:0] rom_idx;

    logic signed [17:0] ramp_sum;
    logic signed [16:0] sine_add;
    logic signed [31:0] prod_bias;
    logic signed [17:0] sine_sum;
    logic signed [15:0] fin_tgt;

    // decision
    logic signed [17:0] band_lo;
    logic signed [17:0] band_hi;
    logic signed [17:0] temp_x;
    logic [31:0]        last_eff;
    logic               chill_go;
    logic               nv;
    logic               out_free;

    assign off = (now_s_reg >= start_reg) ? now_s_reg - start_reg : 32'd0;
    assign el = (now_s_reg >= scs_reg) ? now_s_reg - scs_reg : 32'd0;
    assign el_wrap = (el >= len_reg);
    assign diff = 17'(base_reg) - 17'(rs_reg);
    assign mag = diff[16] ? 16'(-diff) : diff[15:0];
    assign mul = 48'(off) * 48'(mag);
    assign ramp_go = (mode_reg == pht_pkg::MODE_RAMP) && (len_reg != 32'd0) && (off < len_reg);
    assign sine_go = (mode_reg == pht_pkg::MODE_SINE) && (len_reg != 32'd0);

    assign dext = {rem_reg, quo_reg[pht_pkg::QW-1]};
    assign dge = (dext >= {1'b0, len_reg});
    assign dsub = dext - {1'b0, len_reg};

    assign phase = quo_reg[PHASE_BITS-1:0];
    assign rom_idx = pht_pkg::SINE_AW'((32'(phase) << SH_L) >> SH_R);

    assign ramp_sum = neg_reg ? 18'(rs_reg) - 18'(quo_reg) : 18'(rs_reg) + 18'(quo_reg);
    assign prod_bias = prod_reg + 32'sd16384;
    assign sine_add = 17'(prod_bias >>> 15);
    assign sine_sum = 18'(base_reg) + 18'(sine_add);
    assign fin_tgt = (mode_reg == pht_pkg::MODE_RAMP) ? pht_pkg::sat16(ramp_sum)
                                                      : pht_pkg::sat16(sine_sum);

    assign band_lo = 18'(tgt_reg) - 18'(delta_reg);
    assign band_hi = 18'(tgt_reg) + 18'(delta_reg);
    assign temp_x = 18'(temp_reg);
    assign last_eff = (now_ms_reg < last_ms_reg) ? 32'd0 : last_ms_reg;
    assign chill_go = ((now_ms_reg - last_eff) >= pht_pkg::MIN_SWITCH_INTERVAL_MS);

    always_comb
    begin
        nv = drive_reg;
        if (is_heater_reg)
        begin
            priority if (cal_reg)
                nv = 1'b0;
            else if (temp_x <= band_lo)
                nv = 1'b1;
            else if (temp_x >= band_hi)
                nv = 1'b0;
        end
        else if (chill_go)
        begin
            priority if (cal_reg)
                nv = 1'b0;
            else if (temp_x >= band_hi)
                nv = 1'b1;
            else if (temp_x <= band_lo)
                nv = 1'b0;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            ST_PREP:
                state_next = (ramp_go || sine_go) ? ST_DIV : ST_DECIDE;
            ST_DIV:
                if (cnt_reg == 5'd1)
                begin
                    state_next = (mode_reg == pht_pkg::MODE_SINE) ? ST_ROM : ST_FIN;
                end
            ST_ROM:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_FIN;
            ST_FIN:
                state_next = ST_DECIDE;
            ST_DECIDE:
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            is_heater_reg <= 1'b1;
            mode_reg <= pht_pkg::MODE_FLAT;
            base_reg <= 16'sd2000;
            delta_reg <= 13'd5;
            start_reg <= 32'd0;
            len_reg <= 32'd0;
            rs_reg <= 16'sd2000;
            amp_reg <= 16'sd0;
            drive_reg <= 1'b0;
            last_ms_reg <= 32'd0;
            scs_reg <= 32'd0;
            cnt_reg <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pht_pkg::REG_IS_HEATER:
                    begin
                        if (cfg_data[0] != is_heater_reg)
                        begin
                            drive_reg <= 1'b0;
                            last_ms_reg <= 32'd0;
                        end
                        is_heater_reg <= cfg_data[0];
                    end
                    pht_pkg::REG_PROFILE_MODE: mode_reg <= cfg_data[1:0];
                    pht_pkg::REG_BASE_TARGET:  base_reg <= cfg_data[15:0];
                    pht_pkg::REG_HYST_DELTA:   delta_reg <= cfg_data[12:0];
                    pht_pkg::REG_START_TIME:
                    begin
                        start_reg <= cfg_data;
                        scs_reg <= cfg_data;
                    end
                    pht_pkg::REG_LENGTH:       len_reg <= cfg_data;
                    pht_pkg::REG_RAMP_START:   rs_reg <= cfg_data[15:0];
                    pht_pkg::REG_SINE_AMP:     amp_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_PREP)
            begin
                cnt_reg <= (mode_reg == pht_pkg::MODE_SINE) ? 5'(PHASE_BITS) : 5'(pht_pkg::QW);
                if (sine_go && el_wrap)
                begin
                    scs_reg <= now_s_reg;
                end
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg - 5'd1;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DECIDE && out_free)
            begin
                out_valid_reg <= 1'b1;
                drive_reg <= nv;
                if (!is_heater_reg)
                begin
                    last_ms_reg <= chill_go ? now_ms_reg : last_eff;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            now_s_reg <= now_seconds;
            now_ms_reg <= now_ms;
            temp_reg <= temperature;
            cal_reg <= calibrating;
        end
        unique case (state_reg)
            ST_PREP:
            begin
                tgt_reg <= base_reg;
                neg_reg <= diff[16];
                if (sine_go)
                begin
                    // remainder starts below the divisor, dividend tail is zero
                    rem_reg <= el_wrap ? 32'd0 : el;
                    quo_reg <= '0;
                end
                else
                begin
                    rem_reg <= mul[47:16];
                    quo_reg <= mul[15:0];
                end
            end
            ST_DIV:
            begin
                rem_reg <= dge ? dsub[31:0] : dext[31:0];
                quo_reg <= {quo_reg[pht_pkg::QW-2:0], dge};
            end
            ST_ROM:
                rom_reg <= SINE_ROM[rom_idx];
            ST_MUL:
                prod_reg <= 32'(amp_reg) * 32'(rom_reg);
            ST_FIN:
                tgt_reg <= fin_tgt;
            ST_DECIDE:
                if (out_free)
                begin
                    out_drive_reg <= nv;
                    out_tgt_reg <= tgt_reg;
                    out_chg_reg <= (nv != drive_reg);
                end
            default: ;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign drive_on = out_drive_reg;
    assign target_temperature = out_tgt_reg;
    assign drive_changed = out_chg_reg;

endmodule

// File: design/pht_checker.sv
// Port-level checker for the thermostat, bound to the top level.
`include "assert_macros.svh"

module pht_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               drive_on,
    input logic signed [15:0] target_temperature,
    input logic               drive_changed
);

    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "stalled out beat dropped")
    `CHK_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(target_temperature) && $stable(drive_on) && $stable(drive_changed), "stalled out beat changed")
    `CHK_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall, "core not busy after accepted beat")
    `CHK_SAME(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall), "result without work in flight")

endmodule

bind profiled_hysteresis_thermostat_unit pht_checker u_pht_checker (.*);

// File: dv/tb_profiled_hysteresis_thermostat_unit.sv
// Testbench for the profiled hysteresis thermostat: directed and random ticks, scoreboard check.
`timescale 1ns / 100ps

module tb_profiled_hysteresis_thermostat_unit;

    typedef struct packed {
        logic [31:0]        secs;
        logic [31:0]        ms;
        logic signed [15:0] temp;
        logic               cal;
    } tick_t;

    typedef struct packed {
        logic               on;
        logic signed [15:0] target;
        logic               changed;
    } drive_t;

    // Pending items: either a tick or a register write (applied when idle).
    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  idx;
        logic [31:0] data;
        tick_t       tick;
    } job_t;

    localparam int LIMIT_CYCLES = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [31:0] now_seconds;
    logic [31:0] now_ms;
    logic signed [15:0] temperature;
    logic calibrating;
    logic out_valid;
    logic out_stall;
    logic drive_on;
    logic signed [15:0] target_temperature;
    logic drive_changed;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    profiled_hysteresis_thermostat_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .now_seconds(now_seconds), .now_ms(now_ms),
        .temperature(temperature), .calibrating(calibrating),
        .out_valid(out_valid), .out_stall(out_stall),
        .drive_on(drive_on), .target_temperature(target_temperature),
        .drive_changed(drive_changed),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Thermostat model state
    logic        m_heater;
    logic [1:0]  m_mode;
    logic signed [15:0] m_base;
    logic [12:0] m_delta;
    logic [31:0] m_start;
    logic [31:0] m_len;
    logic signed [15:0] m_ramp0;
    logic signed [15:0] m_amp;
    logic        m_drive;
    logic [31:0] m_last_ms;
    logic [31:0] m_cycle_start;
    logic signed [15:0] sine_lut [1024];

    job_t   job_q[$];
    drive_t expected_q[$];
    int     cycles;
    int     mismatches;
    bit     hold_sender;
    bit     quiet;
    int     in_gap;
    int     out_gap;

    // in_stall_seen: the valid beat was not taken at the last rising edge
    logic in_stall_seen;
    int settle;

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // Q30 polynomial for the quarter wave, Q15 rounded and capped
    function automatic int qsine(input int x);
        longint unsigned u, u2, p, s, q;
        u = longint'(x) << 22;
        u2 = (u * u) >> 30;
        p = 172272;
        p = 5026995 - ((p * u2) >> 30);
        p = 85569306 - ((p * u2) >> 30);
        p = 693598669 - ((p * u2) >> 30);
        p = 1686629713 - ((p * u2) >> 30);
        s = (p * u) >> 30;
        q = (s + 16384) >> 15;
        if (q > 32767)
            q = 32767;
        return int'(q);
    endfunction

    task automatic model_reset();
        int v;
        m_heater = 1'b1;
        m_mode = pht_pkg::MODE_FLAT;
        m_base = 16'sd2000;
        m_delta = 13'd5;
        m_start = '0;
        m_len = '0;
        m_ramp0 = 16'sd2000;
        m_amp = '0;
        m_drive = 1'b0;
        m_last_ms = '0;
        m_cycle_start = '0;
        for (int i = 0; i < 1024; i++)
        begin
            v = ((i >> 8) & 1) ? qsine(256 - (i & 255)) : qsine(i & 255);
            sine_lut[i] = 16'(((i >> 8) & 2) ? -v : v);
        end
    endtask

    task automatic model_write(input logic [2:0] idx, input logic [31:0] d);
        case (idx)
            pht_pkg::REG_IS_HEATER:
            begin
                if (d[0] != m_heater)
                begin
                    m_drive = 1'b0;
                    m_last_ms = '0;
                end
                m_heater = d[0];
            end
            pht_pkg::REG_PROFILE_MODE: m_mode = d[1:0];
            pht_pkg::REG_BASE_TARGET: m_base = d[15:0];
            pht_pkg::REG_HYST_DELTA: m_delta = d[12:0];
            pht_pkg::REG_START_TIME:
            begin
                m_start = d;
                m_cycle_start = d;
            end
            pht_pkg::REG_LENGTH: m_len = d;
            pht_pkg::REG_RAMP_START: m_ramp0 = d[15:0];
            pht_pkg::REG_SINE_AMP: m_amp = d[15:0];
            default: ;
        endcase
    endtask

    function automatic logic signed [15:0] setpoint(input logic [31:0] now);
        longint off, num, el, ph, prod, add;
        int idx;
        if (m_mode == pht_pkg::MODE_RAMP)
        begin
            off = (now >= m_start) ? longint'(now - m_start) : 0;
            if (m_len == 0 || off >= longint'(m_len))
                return m_base;
            num = off * (longint'(m_base) - longint'(m_ramp0));
            return clip16(longint'(m_ramp0) + num / longint'(m_len));
        end
        if (m_mode == pht_pkg::MODE_SINE)
        begin
            if (m_len == 0)
                return m_base;
            el = (now >= m_cycle_start) ? longint'(now - m_cycle_start) : 0;
            if (el >= longint'(m_len))
            begin
                m_cycle_start = now;
                el = 0;
            end
            ph = (el << pht_pkg::PHASE_BITS_DEF) / longint'(m_len);
            idx = int'(((ph << 10) >> pht_pkg::PHASE_BITS_DEF) & 1023);
            prod = longint'(m_amp) * longint'(sine_lut[idx]);
            add = ((prod + 1073741824 + 16384) >>> 15) - 32768;
            return clip16(longint'(m_base) + add);
        end
        return m_base;
    endfunction

    function automatic drive_t thermostat_tick(input tick_t t);
        drive_t r;
        logic signed [15:0] sp;
        int lo, hi, tv;
        logic nv;
        sp = setpoint(t.secs);
        lo = int'(sp) - int'(m_delta);
        hi = int'(sp) + int'(m_delta);
        tv = int'(t.temp);
        nv = m_drive;
        if (m_heater)
        begin
            if (t.cal)
                nv = 1'b0;
            else if (tv <= lo)
                nv = 1'b1;
            else if (tv >= hi)
                nv = 1'b0;
        end
        else
        begin
            if (t.ms < m_last_ms)
                m_last_ms = '0;
            if (t.ms - m_last_ms >= pht_pkg::MIN_SWITCH_INTERVAL_MS)
            begin
                m_last_ms = t.ms;
                if (t.cal)
                    nv = 1'b0;
                else if (tv >= hi)
                    nv = 1'b1;
                else if (tv <= lo)
                    nv = 1'b0;
            end
        end
        r.on = nv;
        r.target = sp;
        r.changed = (nv != m_drive);
        m_drive = nv;
        return r;
    endfunction

    // Clock and cycle limit
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Driver: ticks on the input channel; writes wait until everything is back
    always @(negedge clk)
    begin
        logic do_cfg;
        do_cfg = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_stall_seen)
            begin
                // beat still pending; hold
            end
            else if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (job_q.size() > 0 && !hold_sender)
            begin
                if (job_q[0].is_cfg)
                begin
                    in_valid <= 1'b0;
                    if (expected_q.size() == 0 && !in_valid && settle == 0)
                    begin
                        do_cfg = 1'b1;
                        cfg_index <= job_q[0].idx;
                        cfg_data <= job_q[0].data;
                        model_write(job_q[0].idx, job_q[0].data);
                        void'(job_q.pop_front());
                    end
                end
                else
                begin
                    in_valid <= 1'b1;
                    now_seconds <= job_q[0].tick.secs;
                    now_ms <= job_q[0].tick.ms;
                    temperature <= job_q[0].tick.temp;
                    calibrating <= job_q[0].tick.cal;
                    expected_q.push_back(thermostat_tick(job_q[0].tick));
                    void'(job_q.pop_front());
                    if (!quiet && $urandom_range(0, 9) == 0)
                        in_gap <= $urandom_range(1, 7);
                end
            end
            else
                in_valid <= 1'b0;
            cfg_we <= do_cfg;
            if (!quiet && out_gap == 0 && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                out_gap <= $urandom_range(1, 7);
            end
            else if (out_gap > 1)
                out_gap <= out_gap - 1;
            else
            begin
                out_stall <= 1'b0;
                out_gap <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        in_stall_seen <= in_valid && in_stall;
        if (in_valid || expected_q.size() > 0)
            settle <= 25;
        else if (settle > 0)
            settle <= settle - 1;
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        drive_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result beat on=%0b tgt=%0d chg=%0b",
                             drive_on, target_temperature, drive_changed);
            end
            else
            begin
                want = expected_q.pop_front();
                if (want.on !== drive_on || want.target !== target_temperature
                    || want.changed !== drive_changed)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch exp on=%0b tgt=%0d chg=%0b got on=%0b tgt=%0d chg=%0b",
                                 want.on, want.target, want.changed,
                                 drive_on, target_temperature, drive_changed);
                end
            end
        end
    end

    task automatic add_tick(input logic [31:0] s, input logic [31:0] ms,
                            input logic signed [15:0] t, input logic c);
        job_t j;
        j = '0;
        j.tick.secs = s;
        j.tick.ms = ms;
        j.tick.temp = t;
        j.tick.cal = c;
        job_q.push_back(j);
    endtask

    task automatic add_write(input logic [2:0] idx, input logic [31:0] d);
        job_t j;
        j = '0;
        j.is_cfg = 1'b1;
        j.idx = idx;
        j.data = d;
        job_q.push_back(j);
    endtask

    task automatic wait_drained();
        while (job_q.size() > 0 || in_valid || expected_q.size() > 0)
            @(posedge clk);
    endtask

    // Random setup: one of several profile settings, extremes included
    task automatic random_setup(input int k);
        add_write(pht_pkg::REG_IS_HEATER, $urandom_range(0, 1));
        add_write(pht_pkg::REG_PROFILE_MODE, $urandom_range(0, 3));
        case (k % 4)
            0: add_write(pht_pkg::REG_BASE_TARGET, 32'h7FFF);
            1: add_write(pht_pkg::REG_BASE_TARGET, 32'h8000);
            default: add_write(pht_pkg::REG_BASE_TARGET, $urandom_range(0, 6000));
        endcase
        add_write(pht_pkg::REG_HYST_DELTA, (k % 3 == 0) ? 32'd5000 : $urandom_range(0, 300));
        add_write(pht_pkg::REG_START_TIME, $urandom_range(0, 2000));
        case (k % 5)
            0: add_write(pht_pkg::REG_LENGTH, 32'd0);
            1: add_write(pht_pkg::REG_LENGTH, 32'hFFFF_FFFF);
            2: add_write(pht_pkg::REG_LENGTH, 32'd1);
            default: add_write(pht_pkg::REG_LENGTH, $urandom_range(2, 3000));
        endcase
        add_write(pht_pkg::REG_RAMP_START, (k % 2) ? 32'h8000 : $urandom);
        add_write(pht_pkg::REG_SINE_AMP, (k % 3 == 1) ? 32'h7FFF : $urandom);
    endtask

    initial
    begin
        logic [31:0] s, ms;
        cycles = 0;
        mismatches = 0;
        hold_sender = 0;
        quiet = 0;
        in_gap = 0;
        out_gap = 0;
        in_stall_seen = 0;
        settle = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        now_seconds = '0;
        now_ms = '0;
        temperature = '0;
        calibrating = 1'b0;
        cfg_we = 1'b0;
        cfg_index = pht_pkg::REG_IS_HEATER;
        cfg_data = '0;
        model_reset();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: defaults, field extremes, calibration, hold band
        add_tick(32'd0, 32'd0, 16'sh8000, 1'b0);
        add_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sh7FFF, 1'b0);
        add_tick(32'd5, 32'd10, 16'sd1995, 1'b0);
        add_tick(32'd6, 32'd20, 16'sd2000, 1'b0);
        add_tick(32'd7, 32'd30, 16'sd1990, 1'b1);
        add_tick(32'd8, 32'd40, 16'sd1990, 1'b0);
        // ramp with mid progress and before start
        add_write(pht_pkg::REG_PROFILE_MODE, 32'(pht_pkg::MODE_RAMP));
        add_write(pht_pkg::REG_START_TIME, 32'd100);
        add_write(pht_pkg::REG_LENGTH, 32'd1000);
        add_write(pht_pkg::REG_RAMP_START, 32'h8000);
        add_tick(32'd50, 32'd0, 16'sd0, 1'b0);
        add_tick(32'd600, 32'd0, 16'sd0, 1'b0);
        add_tick(32'd1100, 32'd0, 16'sd0, 1'b0);
        // sine including cycle restart
        add_write(pht_pkg::REG_PROFILE_MODE, 32'(pht_pkg::MODE_SINE));
        add_write(pht_pkg::REG_SINE_AMP, 32'h8000);
        add_write(pht_pkg::REG_HYST_DELTA, 32'd5000);
        add_tick(32'd350, 32'd0, 16'sh7FFF, 1'b0);
        add_tick(32'd2500, 32'd0, 16'sd0, 1'b0);
        add_tick(32'd2600, 32'd0, 16'sh8000, 1'b0);
        // chiller interval, backwards clock
        add_write(pht_pkg::REG_IS_HEATER, 32'd0);
        add_tick(32'd0, 32'd40000, 16'sh7FFF, 1'b0);
        add_tick(32'd0, 32'd50000, 16'sh8000, 1'b0);
        add_tick(32'd0, 32'd70000, 16'sh8000, 1'b0);
        add_tick(32'd0, 32'd100, 16'sh7FFF, 1'b0);
        add_tick(32'd0, 32'd30100, 16'sh7FFF, 1'b1);
        add_write(pht_pkg::REG_PROFILE_MODE, 32'd3);
        add_tick(32'd0, 32'd90000, 16'sh7FFF, 1'b0);
        wait_drained();

        // Random rounds; in round 5 the sender pauses until all results are in, and from round 20 gaps and stalls stop
        for (int k = 0; k < 24; k++)
        begin
            if (k == 20)
                quiet = 1;
            random_setup(k);
            s = $urandom_range(0, 4000);
            ms = $urandom;
            for (int n = 0; n < 50; n++)
            begin
                s += $urandom_range(0, 60);
                ms += $urandom_range(0, 40000);
                if ($urandom_range(0, 19) == 0)
                    add_tick($urandom, $urandom, 16'($urandom), 1'($urandom_range(0, 1)));
                else
                    add_tick(s, ms, 16'($urandom_range(0, 8000)) - 16'sd1000,
                             $urandom_range(0, 15) == 0);
            end
            if (k == 5)
            begin
                while (job_q.size() > 25)
                    @(posedge clk);
                hold_sender = 1;
                while (expected_q.size() > 0 || in_valid)
                    @(posedge clk);
                hold_sender = 0;
            end
            wait_drained();
        end
        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
